### hdl/gbk_pkg.sv
`timescale 1ns / 1ps

package gbk_pkg;

  localparam int unsigned DATA_WIDTH = 16;
  localparam int unsigned FRAC_BITS  = 12;

  // internal formats: Q.24 for polynomial values, Q.31 for exp/tanh values
  localparam int unsigned WF = 24;
  localparam int unsigned QF = 31;

  localparam int unsigned SERIES_TERMS = 14;
  localparam int unsigned SQUARINGS    = 6;
  localparam int unsigned X_CLAMP      = 8;

  // datapath widths, sized to the largest value each one can hold
  localparam int unsigned AW   = 28;  // |x| in Q.24, up to 8.0
  localparam int unsigned A2W  = 31;  // x^2, up to 64.0
  localparam int unsigned A3W  = 34;  // x^3, up to 512.0
  localparam int unsigned PW   = 28;  // 1 + 3*a*x^2
  localparam int unsigned MW   = 27;  // c/2 * poly
  localparam int unsigned KA3W = 29;  // a*x^3
  localparam int unsigned IW   = 30;  // x + a*x^3
  localparam int unsigned UW   = 30;  // u
  localparam int unsigned M2W  = 30;  // x * c/2 * poly
  localparam int unsigned HW   = 32;  // Q.31 values up to 1.0 inclusive
  localparam int unsigned NW   = 63;  // tanh numerator
  localparam int unsigned DENW = 33;  // tanh denominator
  localparam int unsigned HTW  = 24;  // tanh/2 in Q.24
  localparam int unsigned QW   = 31;  // derivative term of the tanh slope
  localparam int unsigned DMW  = 32;  // derivative magnitude
  localparam int unsigned RRW  = 24;  // rounded product magnitude
  localparam int unsigned HT_SHIFT  = QF - WF + 1;
  localparam int unsigned DIV_STEPS = HW;

  localparam logic [63:0] ONE_WF = 64'd1 << WF;
  localparam logic [63:0] RND_WF = 64'd1 << (WF - 1);
  localparam logic [63:0] RND_QF = 64'd1 << (QF - 1);
  localparam logic [HW-1:0] ONE_QF = HW'(64'd1 << QF);

  // exponent argument limit: 64.0 in Q.24, minus one LSB
  localparam logic [UW:0] V_LIM = (UW + 1)'((64'd64 << WF) - 64'd1);
  localparam logic [DATA_WIDTH:0] X_LIM = (DATA_WIDTH + 1)'(X_CLAMP << FRAC_BITS);

  localparam logic [RRW-1:0] POS_LIM = RRW'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
  localparam logic [RRW-1:0] NEG_LIM = RRW'(64'd1 << (DATA_WIDTH - 1));

  // constants in Q.24
  localparam logic [23:0] K_C  = 24'd13386282;  // sqrt(2/pi)
  localparam logic [22:0] K_HC = 23'd6693141;   // sqrt(2/pi)/2
  localparam logic [19:0] K_A  = 20'd750193;    // 0.044715
  localparam logic [21:0] K_A3 = 22'd2250580;   // 3*0.044715

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] pre_activation;
    logic signed [DATA_WIDTH-1:0] upstream_grad;
  } gbk_req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] input_grad;
    logic                         saturated;
  } gbk_rsp_t;

endpackage

### hdl/gelu_backward_kernel_top.sv
`timescale 1ns / 1ps

// GELU backward (tanh form), fully pipelined: one request is accepted per clock while
// in_stall_o is low, with no dependence on data.
// The pipeline is a chain of stages: five for the x^2/x^3 polynomial, two per
// term of a 14-term exp series (multiply, then divide by the term index through a
// reciprocal), six squaring stages, one setup stage and a 32-stage restoring divider for
// tanh, then five stages for the slope, the gradient product and rounding/saturation.
// A stall on the output is absorbed by a one-entry skid register; while that register is
// occupied in_stall_o is high and the whole pipeline holds.
module gelu_backward_kernel_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  gbk_pkg::gbk_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output gbk_pkg::gbk_rsp_t out_rsp_o
);
  import gbk_pkg::*;

  typedef struct packed {
    logic                  xneg;
    logic                  gneg;
    logic [DATA_WIDTH-1:0] gm;
    logic [M2W-1:0]        m2;
  } side_t;

  logic en;
  logic skid_vld_q, skid_vld_d;
  gbk_rsp_t skid_rsp_q;

  assign en = ~skid_vld_q;

  // ---------------- stage 1: magnitudes and clamp ----------------
  logic          s1_vld_q;
  logic [AW-1:0] s1_a_q, s1_a_d;
  side_t         s1_sd_q, s1_sd_d;

  always_comb begin
    logic [DATA_WIDTH-1:0] x_raw, g_raw, ax;
    x_raw = in_req_i.pre_activation;
    g_raw = in_req_i.upstream_grad;
    s1_sd_d.xneg = x_raw[DATA_WIDTH-1];
    s1_sd_d.gneg = g_raw[DATA_WIDTH-1];
    s1_sd_d.gm   = s1_sd_d.gneg ? (~g_raw + 1'b1) : g_raw;
    s1_sd_d.m2   = '0;
    ax = s1_sd_d.xneg ? (~x_raw + 1'b1) : x_raw;
    if ({1'b0, ax} > X_LIM) begin
      ax = X_LIM[DATA_WIDTH-1:0];
    end
    s1_a_d = AW'(ax) << (WF - FRAC_BITS);
  end

  // ---------------- stage 2: x^2 ----------------
  logic           s2_vld_q;
  logic [AW-1:0]  s2_a_q;
  logic [A2W-1:0] s2_a2_q, s2_a2_d;
  side_t          s2_sd_q;

  always_comb begin
    logic [55:0] prod;
    prod    = 56'(s1_a_q) * 56'(s1_a_q) + 56'(RND_WF);
    s2_a2_d = prod[WF +: A2W];
  end

  // ---------------- stage 3: x^3 and 1 + 3*a*x^2 ----------------
  logic           s3_vld_q;
  logic [AW-1:0]  s3_a_q;
  logic [A3W-1:0] s3_a3_q, s3_a3_d;
  logic [PW-1:0]  s3_poly_q, s3_poly_d;
  side_t          s3_sd_q;

  always_comb begin
    logic [63:0] prod_c, prod_p;
    prod_c    = 64'(s2_a2_q) * 64'(s2_a_q) + RND_WF;
    s3_a3_d   = prod_c[WF +: A3W];
    prod_p    = 64'(K_A3) * 64'(s2_a2_q) + RND_WF;
    s3_poly_d = PW'(ONE_WF) + prod_p[WF +: PW];
  end

  // ---------------- stage 4: a*x^3 and c/2*poly ----------------
  logic            s4_vld_q;
  logic [AW-1:0]   s4_a_q;
  logic [KA3W-1:0] s4_ka3_q, s4_ka3_d;
  logic [MW-1:0]   s4_m_q, s4_m_d;
  side_t           s4_sd_q;

  always_comb begin
    logic [63:0] prod_k, prod_m;
    prod_k   = 64'(K_A) * 64'(s3_a3_q) + RND_WF;
    s4_ka3_d = prod_k[WF +: KA3W];
    prod_m   = 64'(K_HC) * 64'(s3_poly_q) + RND_WF;
    s4_m_d   = prod_m[WF +: MW];
  end

  // ---------------- stage 5: u and x*m ----------------
  logic          s5_vld_q;
  logic [UW-1:0] s5_u_q, s5_u_d;
  side_t         s5_sd_q, s5_sd_d;

  always_comb begin
    logic [IW-1:0] inner;
    logic [63:0]   prod_u, prod_m2;
    inner   = IW'(s4_a_q) + IW'(s4_ka3_q);
    prod_u  = 64'(K_C) * 64'(inner) + RND_WF;
    s5_u_d  = prod_u[WF +: UW];
    prod_m2 = 64'(s4_m_q) * 64'(s4_a_q) + RND_WF;
    s5_sd_d    = s4_sd_q;
    s5_sd_d.m2 = prod_m2[WF +: M2W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_a_q    <= s1_a_d;
      s1_sd_q   <= s1_sd_d;
      s2_a_q    <= s1_a_q;
      s2_a2_q   <= s2_a2_d;
      s2_sd_q   <= s1_sd_q;
      s3_a_q    <= s2_a_q;
      s3_a3_q   <= s3_a3_d;
      s3_poly_q <= s3_poly_d;
      s3_sd_q   <= s2_sd_q;
      s4_a_q    <= s3_a_q;
      s4_ka3_q  <= s4_ka3_d;
      s4_m_q    <= s4_m_d;
      s4_sd_q   <= s3_sd_q;
      s5_u_q    <= s5_u_d;
      s5_sd_q   <= s5_sd_d;
    end
  end

  // ---------------- exp series: e^(-r), r = 2u/64, Horner from the top term ----------------
  logic          sa_vld_q [SERIES_TERMS];
  logic [HW-1:0] sa_p_q   [SERIES_TERMS];
  logic [HW-1:0] sa_r_q   [SERIES_TERMS];
  side_t         sa_sd_q  [SERIES_TERMS];
  logic          sb_vld_q [SERIES_TERMS];
  logic [HW-1:0] sb_h_q   [SERIES_TERMS];
  logic [HW-1:0] sb_r_q   [SERIES_TERMS];
  side_t         sb_sd_q  [SERIES_TERMS];

  for (genvar j = 0; j < SERIES_TERMS; j++) begin : g_term
    localparam int unsigned TermN  = SERIES_TERMS - j;
    localparam int unsigned TermLg = $clog2(TermN);
    // exact floor division by TermN for 32-bit dividends
    localparam logic [63:0] TermRecip =
      ((64'd1 << (HW + TermLg)) + 64'(TermN) - 64'd1) / 64'(TermN);
    localparam logic [HW-1:0] TermHalf = HW'(TermN / 2);

    logic          vld_in;
    logic [HW-1:0] r_in, h_in;
    side_t         sd_in;
    logic [HW-1:0] p_d, h_d;

    if (j == 0) begin : g_first
      always_comb begin
        logic [UW:0] v;
        v = {s5_u_q, 1'b0};
        if (v > V_LIM) begin
          v = V_LIM;
        end
        r_in = HW'({v, 1'b0});
      end
      assign vld_in = s5_vld_q;
      assign h_in   = ONE_QF;
      assign sd_in  = s5_sd_q;
    end else begin : g_next
      assign vld_in = sb_vld_q[j-1];
      assign r_in   = sb_r_q[j-1];
      assign h_in   = sb_h_q[j-1];
      assign sd_in  = sb_sd_q[j-1];
    end

    always_comb begin
      logic [63:0] prod;
      prod = 64'(r_in) * 64'(h_in) + RND_QF;
      p_d  = prod[QF +: HW];
    end

    always_comb begin
      logic [HW-1:0] v;
      logic [71:0]   prod;
      v    = sa_p_q[j] + TermHalf;
      prod = 72'(v) * 72'(TermRecip[HW:0]);
      h_d  = ONE_QF - prod[HW + TermLg +: HW];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sa_vld_q[j] <= 1'b0;
        sb_vld_q[j] <= 1'b0;
      end else if (en) begin
        sa_vld_q[j] <= vld_in;
        sb_vld_q[j] <= sa_vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sa_p_q[j]  <= p_d;
        sa_r_q[j]  <= r_in;
        sa_sd_q[j] <= sd_in;
        sb_h_q[j]  <= h_d;
        sb_r_q[j]  <= sa_r_q[j];
        sb_sd_q[j] <= sa_sd_q[j];
      end
    end
  end

  // ---------------- squarings: (e^(-r))^64 ----------------
  logic          sq_vld_q [SQUARINGS];
  logic [HW-1:0] sq_h_q   [SQUARINGS];
  side_t         sq_sd_q  [SQUARINGS];

  for (genvar k = 0; k < SQUARINGS; k++) begin : g_sq
    logic          vld_in;
    logic [HW-1:0] h_in, h_d;
    side_t         sd_in;

    if (k == 0) begin : g_first
      assign vld_in = sb_vld_q[SERIES_TERMS-1];
      assign h_in   = sb_h_q[SERIES_TERMS-1];
      assign sd_in  = sb_sd_q[SERIES_TERMS-1];
    end else begin : g_next
      assign vld_in = sq_vld_q[k-1];
      assign h_in   = sq_h_q[k-1];
      assign sd_in  = sq_sd_q[k-1];
    end

    always_comb begin
      logic [63:0] prod;
      prod = 64'(h_in) * 64'(h_in) + RND_QF;
      h_d  = prod[QF +: HW];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[k] <= 1'b0;
      end else if (en) begin
        sq_vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_h_q[k]  <= h_d;
        sq_sd_q[k] <= sd_in;
      end
    end
  end

  // ---------------- tanh setup: (1-e)/(1+e), rounded ----------------
  logic            pr_vld_q;
  logic [NW-1:0]   pr_num_q, pr_num_d;
  logic [DENW-1:0] pr_den_q, pr_den_d;
  side_t           pr_sd_q;

  always_comb begin
    logic [HW-1:0] e;
    e        = sq_h_q[SQUARINGS-1];
    pr_den_d = DENW'(ONE_QF) + DENW'(e);
    pr_num_d = (NW'(ONE_QF - e) << QF) + NW'(pr_den_d >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_vld_q <= 1'b0;
    end else if (en) begin
      pr_vld_q <= sq_vld_q[SQUARINGS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr_num_q <= pr_num_d;
      pr_den_q <= pr_den_d;
      pr_sd_q  <= sq_sd_q[SQUARINGS-1];
    end
  end

  // ---------------- restoring divider, one quotient bit per stage ----------------
  logic            dv_vld_q [DIV_STEPS];
  logic [HW-1:0]   dv_rem_q [DIV_STEPS];
  logic [HW-1:0]   dv_qt_q  [DIV_STEPS];
  logic [HW-1:0]   dv_lo_q  [DIV_STEPS];
  logic [DENW-1:0] dv_den_q [DIV_STEPS];
  side_t           dv_sd_q  [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int unsigned BitIdx = HW - 1 - k;

    logic            vld_in;
    logic [HW-1:0]   rem_in, qt_in, lo_in, rem_d, qt_d;
    logic [DENW-1:0] den_in;
    side_t           sd_in;

    if (k == 0) begin : g_first
      // upper numerator bits are always below the divisor
      assign vld_in = pr_vld_q;
      assign rem_in = HW'(pr_num_q[NW-1:HW]);
      assign qt_in  = '0;
      assign lo_in  = pr_num_q[HW-1:0];
      assign den_in = pr_den_q;
      assign sd_in  = pr_sd_q;
    end else begin : g_next
      assign vld_in = dv_vld_q[k-1];
      assign rem_in = dv_rem_q[k-1];
      assign qt_in  = dv_qt_q[k-1];
      assign lo_in  = dv_lo_q[k-1];
      assign den_in = dv_den_q[k-1];
      assign sd_in  = dv_sd_q[k-1];
    end

    always_comb begin
      logic [DENW-1:0] r2;
      logic            ge;
      r2    = {rem_in, lo_in[BitIdx]};
      ge    = (r2 >= den_in);
      rem_d = ge ? HW'(r2 - den_in) : r2[HW-1:0];
      qt_d  = {qt_in[HW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k] <= 1'b0;
      end else if (en) begin
        dv_vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_rem_q[k] <= rem_d;
        dv_qt_q[k]  <= qt_d;
        dv_lo_q[k]  <= lo_in;
        dv_den_q[k] <= den_in;
        dv_sd_q[k]  <= sd_in;
      end
    end
  end

  // ---------------- tail: slope, derivative, gradient product, saturation ----------------
  logic           ts_vld_q;
  logic [HW-1:0]  ts_s_q, ts_s_d;
  logic [HTW-1:0] ts_ht_q, ts_ht_d;
  side_t          ts_sd_q;

  always_comb begin
    logic [HW-1:0] t;
    logic [63:0]   prod;
    logic [HW:0]   rsum;
    t       = dv_qt_q[DIV_STEPS-1];
    prod    = 64'(t) * 64'(t) + RND_QF;
    ts_s_d  = ONE_QF - prod[QF +: HW];
    rsum    = (HW + 1)'(t) + (HW + 1)'(64'd1 << (HT_SHIFT - 1));
    ts_ht_d = rsum[HT_SHIFT +: HTW];
  end

  logic           qs_vld_q;
  logic [QW-1:0]  qs_q_q, qs_q_d;
  logic [HTW-1:0] qs_ht_q;
  side_t          qs_sd_q;

  always_comb begin
    logic [63:0] prod;
    prod   = 64'(ts_sd_q.m2) * 64'(ts_s_q) + RND_QF;
    qs_q_d = prod[QF +: QW];
  end

  logic           dm_vld_q;
  logic [DMW-1:0] dm_mag_q, dm_mag_d;
  logic           dm_neg_q, dm_neg_d;
  side_t          dm_sd_q;

  always_comb begin
    logic [DMW-1:0] tsum, half;
    tsum = DMW'(qs_ht_q) + DMW'(qs_q_q);
    half = DMW'(ONE_WF >> 1);
    dm_neg_d = 1'b0;
    if (!qs_sd_q.xneg) begin
      dm_mag_d = half + tsum;
    end else if (tsum > half) begin
      dm_mag_d = tsum - half;
      dm_neg_d = 1'b1;
    end else begin
      dm_mag_d = half - tsum;
    end
  end

  logic           rr_vld_q;
  logic [RRW-1:0] rr_mag_q, rr_mag_d;
  logic           rr_neg_q;
  side_t          rr_sd_q;

  always_comb begin
    logic [47:0] prod;
    prod     = 48'(dm_sd_q.gm) * 48'(dm_mag_q) + 48'(RND_WF);
    rr_mag_d = prod[WF +: RRW];
  end

  logic     lst_vld_q;
  gbk_rsp_t lst_rsp_q, lst_rsp_d;

  always_comb begin
    logic           rneg;
    logic [RRW-1:0] r;
    rneg = (rr_sd_q.gneg != rr_neg_q) && (rr_mag_q != '0);
    r    = rr_mag_q;
    lst_rsp_d.saturated = 1'b0;
    if (rneg && (r > NEG_LIM)) begin
      r = NEG_LIM;
      lst_rsp_d.saturated = 1'b1;
    end else if (!rneg && (r > POS_LIM)) begin
      r = POS_LIM;
      lst_rsp_d.saturated = 1'b1;
    end
    lst_rsp_d.input_grad = rneg ? DATA_WIDTH'(~r + 1'b1) : DATA_WIDTH'(r);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_vld_q  <= 1'b0;
      qs_vld_q  <= 1'b0;
      dm_vld_q  <= 1'b0;
      rr_vld_q  <= 1'b0;
      lst_vld_q <= 1'b0;
    end else if (en) begin
      ts_vld_q  <= dv_vld_q[DIV_STEPS-1];
      qs_vld_q  <= ts_vld_q;
      dm_vld_q  <= qs_vld_q;
      rr_vld_q  <= dm_vld_q;
      lst_vld_q <= rr_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ts_s_q    <= ts_s_d;
      ts_ht_q   <= ts_ht_d;
      ts_sd_q   <= dv_sd_q[DIV_STEPS-1];
      qs_q_q    <= qs_q_d;
      qs_ht_q   <= ts_ht_q;
      qs_sd_q   <= ts_sd_q;
      dm_mag_q  <= dm_mag_d;
      dm_neg_q  <= dm_neg_d;
      dm_sd_q   <= qs_sd_q;
      rr_mag_q  <= rr_mag_d;
      rr_neg_q  <= dm_neg_q;
      rr_sd_q   <= dm_sd_q;
      lst_rsp_q <= lst_rsp_d;
    end
  end

  // ---------------- output skid ----------------
  // the last stage moves here when the consumer stalls, so the pipe never drops it
  always_comb begin
    if (skid_vld_q) begin
      skid_vld_d = out_stall_i;
    end else begin
      skid_vld_d = lst_vld_q & out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else begin
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_vld_q) begin
      skid_rsp_q <= lst_rsp_q;
    end
  end

  assign in_stall_o  = skid_vld_q;
  assign out_valid_o = skid_vld_q | lst_vld_q;
  assign out_rsp_o   = skid_vld_q ? skid_rsp_q : lst_rsp_q;

`ifndef SYNTHESIS
  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_stall_i) && $past(lst_vld_q))
    else $error("skid filled without a stalled result");

  a_pipe_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |=> $stable(lst_vld_q) && $stable(lst_rsp_q))
    else $error("pipeline moved while skid occupied");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q && !out_stall_i |=> !skid_vld_q)
    else $error("skid did not drain after acceptance");

  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.saturated |->
      (out_rsp_o.input_grad == DATA_WIDTH'(POS_LIM)) ||
      (out_rsp_o.input_grad == DATA_WIDTH'(NEG_LIM)))
    else $error("saturation flag set on an unclipped result");
`endif

endmodule
